@@ src/tcw_pkg.sv @@
// shared types and constants of the text console character writer
package tcw_pkg;

	// command codes on the cmd field
	localparam logic [1:0] CMD_PUT    = 2'd0;
	localparam logic [1:0] CMD_READ   = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;
	localparam logic [1:0] CMD_SETCUR = 2'd3;

	// control characters
	localparam logic [7:0] CH_BELL    = 8'd7;
	localparam logic [7:0] CH_TAB     = 8'd9;
	localparam logic [7:0] CH_NEWLINE = 8'd10;

	localparam logic [7:0] BLANK = 8'h20;
	localparam logic [7:0] ATTR  = 8'h07;

	// depth of the queue between front and back
	localparam int QDEPTH = 2;

	typedef enum logic [2:0] {
		OP_CHAR,
		OP_NEWLINE,
		OP_TAB,
		OP_BELL,
		OP_READ,
		OP_CLEAR,
		OP_SETCUR,
		OP_NOP
	} op_kind_t;

	typedef struct packed {
		op_kind_t    kind;
		logic [7:0]  ch;
		logic        eot;
		logic [10:0] addr;
		logic        in_range;
		logic [7:0]  col;
		logic [7:0]  row;
	} op_t;

endpackage

@@ src/tcw_front.sv @@
// command intake: decodes each transaction into an operation and queues it for the back end
module tcw_front #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	input  logic [1:0]       cmd,
	input  logic [7:0]       char_code,
	input  logic             end_of_text,
	input  logic [10:0]      cell_address,
	input  logic [7:0]       new_col,
	input  logic [7:0]       new_row,
	input  logic             hold,
	output logic             q_valid,
	output tcw_pkg::op_t     q_op,
	input  logic             q_pop
);
	import tcw_pkg::*;

	localparam int CELLS = ROWS * COLUMNS;
	localparam int QPW   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCW   = $clog2(QDEPTH + 1);

	op_t            op_dec;
	op_t            q_mem_q [QDEPTH];
	logic [QPW-1:0] wr_ptr_q;
	logic [QPW-1:0] rd_ptr_q;
	logic [QCW-1:0] count_q;
	logic           push;

	always_comb begin
		op_dec          = '0;
		op_dec.ch       = char_code;
		op_dec.eot      = end_of_text;
		op_dec.addr     = cell_address;
		op_dec.col      = new_col;
		op_dec.row      = new_row;
		op_dec.in_range = cell_address < CELLS;
		case (cmd)
			CMD_PUT: begin
				case (char_code)
					CH_NEWLINE: op_dec.kind = OP_NEWLINE;
					CH_TAB:     op_dec.kind = OP_TAB;
					CH_BELL:    op_dec.kind = OP_BELL;
					default:    op_dec.kind = OP_CHAR;
				endcase
			end
			CMD_READ:  op_dec.kind = OP_READ;
			CMD_CLEAR: op_dec.kind = OP_CLEAR;
			CMD_SETCUR: begin
				// out-of-range positions turn the command into a no-op; column COLUMNS means wrap pending
				if (new_col <= COLUMNS && new_row < ROWS) begin
					op_dec.kind = OP_SETCUR;
				end else begin
					op_dec.kind = OP_NOP;
				end
			end
			default: op_dec.kind = OP_NOP;
		endcase
	end

	assign cmd_stall = (count_q == QCW'(QDEPTH)) || hold;
	assign push      = cmd_valid && !cmd_stall;
	assign q_valid   = count_q != '0;
	assign q_op      = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= op_dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPW'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPW'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPW'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPW'(1);
			end
			count_q <= count_q + QCW'(push) - QCW'(q_pop);
		end
	end

endmodule

@@ src/tcw_back.sv @@
// execution engine: screen store, cursor, scroll and clear sweeps, result register
module tcw_back #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  tcw_pkg::op_t     q_op,
	output logic             q_pop,
	output logic             init_busy,
	output logic             res_valid,
	input  logic             res_stall,
	output logic [6:0]       cursor_col,
	output logic [4:0]       cursor_row,
	output logic [10:0]      cursor_offset,
	output logic             cursor_update,
	output logic             beep,
	output logic             scrolled,
	output logic [15:0]      cell_word
);
	import tcw_pkg::*;

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam int PW    = $clog2(CELLS + 1);
	localparam int OFFW  = $clog2(CELLS + 1);
	localparam int XW    = $clog2(COLUMNS + 1);
	localparam int YW    = $clog2(ROWS);

	typedef enum logic [5:0] {
		ST_INIT   = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_SCROLL = 6'b000100,
		ST_EXEC   = 6'b001000,
		ST_CLEAR  = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	state_t          state_q;
	op_t             op_q;
	logic [XW-1:0]   x_q;
	logic [YW-1:0]   y_q;
	logic [PW-1:0]   ptr_q;
	logic            beep_q;
	logic            scrolled_q;

	logic [7:0]      screen_q [CELLS];
	logic [7:0]      rdata_q;

	// scroll copy: the write follows the read in the next cycle
	logic            wr_vld_s1;
	logic [AW-1:0]   wr_idx_s1;
	logic            wr_blank_s1;

	logic            we;
	logic [AW-1:0]   waddr;
	logic [7:0]      wdata;
	logic            rd_en;
	logic [AW-1:0]   raddr;

	logic [OFFW-1:0] offset;
	logic [OFFW+10:0] off_ext;
	logic [XW+6:0]   x_ext;
	logic [YW+4:0]   y_ext;
	logic [AW+10:0]  addr_ext;
	logic [PW-1:0]   src;
	logic            bottom_row;
	logic [XW-1:0]   x_nxt;
	logic            tab_done;
	logic            out_free;

	assign offset     = OFFW'(y_q) * OFFW'(COLUMNS) + OFFW'(x_q);
	assign off_ext    = {11'b0, offset};
	assign x_ext      = {7'b0, x_q};
	assign y_ext      = {5'b0, y_q};
	assign addr_ext   = {{AW{1'b0}}, q_op.addr};
	assign src        = ptr_q + PW'(COLUMNS);
	assign bottom_row = ptr_q >= PW'(CELLS - COLUMNS);
	assign x_nxt      = x_q + XW'(1);
	assign tab_done   = (x_nxt[2:0] == 3'b000) || (x_nxt == XW'(COLUMNS));
	assign out_free   = !res_valid || !res_stall;

	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign init_busy = state_q == ST_INIT;

	// read port
	always_comb begin
		rd_en = 1'b0;
		raddr = addr_ext[AW-1:0];
		case (state_q)
			ST_IDLE: rd_en = q_valid && q_op.kind == OP_READ && q_op.in_range;
			ST_SCROLL: begin
				rd_en = (ptr_q != PW'(CELLS)) && !bottom_row;
				raddr = src[AW-1:0];
			end
			default: rd_en = 1'b0;
		endcase
	end

	// write port
	always_comb begin
		we    = 1'b0;
		waddr = offset[AW-1:0];
		wdata = BLANK;
		if (wr_vld_s1) begin
			we    = 1'b1;
			waddr = wr_idx_s1;
			wdata = wr_blank_s1 ? BLANK : rdata_q;
		end else begin
			case (state_q)
				ST_INIT, ST_CLEAR: begin
					we    = 1'b1;
					waddr = ptr_q[AW-1:0];
				end
				ST_EXEC: begin
					if (op_q.kind == OP_CHAR) begin
						we    = 1'b1;
						wdata = op_q.ch;
					end else if (op_q.kind == OP_TAB) begin
						we = 1'b1;
					end
				end
				default: we = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			screen_q[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= screen_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_q <= q_op;
		end
		wr_idx_s1   <= ptr_q[AW-1:0];
		wr_blank_s1 <= bottom_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_INIT;
			x_q           <= '0;
			y_q           <= '0;
			ptr_q         <= '0;
			beep_q        <= 1'b0;
			scrolled_q    <= 1'b0;
			wr_vld_s1     <= 1'b0;
			res_valid     <= 1'b0;
			cursor_col    <= '0;
			cursor_row    <= '0;
			cursor_offset <= '0;
			cursor_update <= 1'b0;
			beep          <= 1'b0;
			scrolled      <= 1'b0;
			cell_word     <= '0;
		end else begin
			wr_vld_s1 <= 1'b0;
			if (res_valid && !res_stall) begin
				res_valid <= 1'b0;
			end
			case (state_q)
				ST_INIT, ST_CLEAR: begin
					ptr_q <= ptr_q + PW'(1);
					if (ptr_q == PW'(CELLS - 1)) begin
						state_q <= (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
					end
				end
				ST_IDLE: begin
					if (q_valid) begin
						beep_q     <= 1'b0;
						scrolled_q <= 1'b0;
						if (q_op.kind inside {OP_CHAR, OP_NEWLINE, OP_TAB, OP_BELL}) begin
							if (q_op.kind == OP_NEWLINE || x_q == XW'(COLUMNS)) begin
								x_q <= '0;
								if (y_q == YW'(ROWS - 1)) begin
									scrolled_q <= 1'b1;
									ptr_q      <= '0;
									state_q    <= ST_SCROLL;
								end else begin
									y_q     <= y_q + YW'(1);
									state_q <= (q_op.kind == OP_NEWLINE) ? ST_DONE : ST_EXEC;
								end
							end else begin
								state_q <= ST_EXEC;
							end
						end else begin
							case (q_op.kind)
								OP_CLEAR: begin
									x_q     <= '0;
									y_q     <= '0;
									ptr_q   <= '0;
									state_q <= ST_CLEAR;
								end
								OP_SETCUR: begin
									x_q     <= q_op.col[XW-1:0];
									y_q     <= q_op.row[YW-1:0];
									state_q <= ST_DONE;
								end
								default: state_q <= ST_DONE;
							endcase
						end
					end
				end
				ST_SCROLL: begin
					if (ptr_q != PW'(CELLS)) begin
						wr_vld_s1 <= 1'b1;
						ptr_q     <= ptr_q + PW'(1);
					end else begin
						// last copy write lands on this edge
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					case (op_q.kind)
						OP_CHAR: begin
							x_q     <= x_nxt;
							state_q <= ST_DONE;
						end
						OP_TAB: begin
							x_q <= x_nxt;
							if (tab_done) begin
								state_q <= ST_DONE;
							end
						end
						OP_BELL: begin
							beep_q  <= 1'b1;
							state_q <= ST_DONE;
						end
						default: state_q <= ST_DONE;
					endcase
				end
				ST_DONE: begin
					if (out_free) begin
						res_valid     <= 1'b1;
						cursor_col    <= x_ext[6:0];
						cursor_row    <= y_ext[4:0];
						cursor_offset <= off_ext[10:0];
						beep          <= beep_q;
						scrolled      <= scrolled_q;
						cell_word     <= (op_q.kind == OP_READ && op_q.in_range) ?
							{ATTR, rdata_q} : 16'h0000;
						case (op_q.kind)
							OP_CHAR, OP_NEWLINE, OP_TAB, OP_BELL: cursor_update <= op_q.eot;
							OP_CLEAR, OP_SETCUR:                  cursor_update <= 1'b1;
							default:                              cursor_update <= 1'b0;
						endcase
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ src/text_console_character_writer_unit.sv @@
// top level of the text console character writer: command queue front end and execution back end
// commands pass from the queue through the execution states to the result register; one command
// runs at a time while the queue in front can take further commands; a tab writes a blank per
// column up to the next multiple of 8 or the line end, a put that scrolls first moves every row
// up one and blanks the bottom row, a clear screen blanks every cell; the store has one write and
// one read port; after reset a blanking sweep fills every cell and no command is taken meanwhile
module text_console_character_writer_unit #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [1:0]  cmd,
	input  logic [7:0]  char_code,
	input  logic        end_of_text,
	input  logic [10:0] cell_address,
	input  logic [7:0]  new_col,
	input  logic [7:0]  new_row,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [6:0]  cursor_col,
	output logic [4:0]  cursor_row,
	output logic [10:0] cursor_offset,
	output logic        cursor_update,
	output logic        beep,
	output logic        scrolled,
	output logic [15:0] cell_word
);
	import tcw_pkg::*;

	logic q_valid;
	op_t  q_op;
	logic q_pop;
	logic init_busy;

	tcw_front #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.cmd         (cmd),
		.char_code   (char_code),
		.end_of_text (end_of_text),
		.cell_address(cell_address),
		.new_col     (new_col),
		.new_row     (new_row),
		.hold        (init_busy),
		.q_valid     (q_valid),
		.q_op        (q_op),
		.q_pop       (q_pop)
	);

	tcw_back #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_op         (q_op),
		.q_pop        (q_pop),
		.init_busy    (init_busy),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.cursor_col   (cursor_col),
		.cursor_row   (cursor_row),
		.cursor_offset(cursor_offset),
		.cursor_update(cursor_update),
		.beep         (beep),
		.scrolled     (scrolled),
		.cell_word    (cell_word)
	);

endmodule
